@@ rtl/core/bcpe_pkg.sv @@
// Shared types, codes and constants of the B-spline curve point evaluator.
`default_nettype none
package bcpe_pkg;

  localparam int NUM_CTRL_DEF = 13;
  localparam int ORDER_DEF    = 4;

  localparam int IDX_W   = 6;   // table index width (slot field)
  localparam int K_W     = 3;   // order counter
  localparam int BAS_W   = 26;  // basis / coefficient, signed Q.16 within +-2^24
  localparam int ACC_W   = 48;  // curve accumulator
  localparam int ONE_Q16 = 65536;
  localparam int BAS_LIM = 16777216;

  typedef enum logic [1:0] {
    OP_WR_KNOT = 2'd0,
    OP_WR_CTRL = 2'd1,
    OP_EVAL    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CAP_A = 2'd0,
    CAP_B = 2'd1,
    CAP_C = 2'd2,
    CAP_D = 2'd3
  } cap_t;

  typedef enum logic {
    COEF_1 = 1'b0,
    COEF_2 = 1'b1
  } coef_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_INIT_WR,
    S_C1,
    S_C1W,
    S_C2,
    S_C2W,
    S_MUL,
    S_SUM,
    S_BWR,
    S_A_RD,
    S_A_MUL,
    S_A_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             t_load;
    logic             knot_we;
    logic             ctrl_we;
    logic [IDX_W-1:0] knot_addr;
    logic [IDX_W-1:0] work_addr;
    logic             cap_en;
    cap_t             cap_sel;
    logic             init_we;
    logic             coef_start;
    coef_t            coef_sel;
    logic             mul_en;
    logic             sum_en;
    logic             basis_we;
    logic             acc_mul;
    logic             acc_add;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic coef_busy;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/core/bcpe_div.sv @@
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
`default_nettype none
module bcpe_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [15:0] den,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quo
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [15:0] den_r, den_nxt;
  logic [16:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    trial    = {rem_r, q_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 16'(trial - {1'b0, den_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

@@ rtl/core/bcpe_datapath.sv @@
// Datapath: knot, control point and basis stores, coefficient unit, multipliers, accumulators.
`default_nettype none
module bcpe_datapath #(
  parameter int NUM_CTRL = bcpe_pkg::NUM_CTRL_DEF,
  parameter int ORDER    = bcpe_pkg::ORDER_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bcpe_pkg::cmd_t      cmd,
  output bcpe_pkg::stat_t          stat,
  input  wire logic [5:0]          in_slot,
  input  wire logic [15:0]         in_knot_value,
  input  wire logic signed [15:0]  in_point_x,
  input  wire logic signed [15:0]  in_point_y,
  input  wire logic [15:0]         in_param_t,
  output logic signed [15:0]       out_curve_x,
  output logic signed [15:0]       out_curve_y
);

  localparam int NK  = NUM_CTRL + ORDER;
  localparam int NW  = NK - 1;
  localparam int KAW = $clog2(NK);
  localparam int WAW = $clog2(NW);
  localparam int CAW = $clog2(NUM_CTRL);
  localparam int BW  = bcpe_pkg::BAS_W;
  localparam int AW  = bcpe_pkg::ACC_W;

  function automatic logic signed [BW-1:0] basis_rnd(input logic signed [52:0] v);
    logic [52:0]        mag;
    logic [36:0]        sh;
    logic signed [37:0] r;
    mag = v[52] ? 53'(-v) : 53'(v);
    sh  = 37'((mag + 53'd32768) >> 16);
    r   = v[52] ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
    if (r > 38'sd16777216) r = 38'sd16777216;
    else if (r < -38'sd16777216) r = -38'sd16777216;
    return BW'(r);
  endfunction

  function automatic logic signed [15:0] curve_rnd(input logic signed [AW-1:0] v);
    logic [AW-1:0]        mag;
    logic [AW-17:0]       sh;
    logic signed [AW-16:0] r;
    mag = v[AW-1] ? AW'(-v) : AW'(v);
    sh  = (AW-16)'((mag + AW'(32768)) >> 16);
    r   = v[AW-1] ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
    if (r > (AW-15)'(32767)) r = (AW-15)'(32767);
    else if (r < -(AW-15)'(32768)) r = -(AW-15)'(32768);
    return 16'(r);
  endfunction

  // stores
  logic [15:0]          knot_mem [NK];
  logic [31:0]          ctrl_mem [NUM_CTRL];
  logic signed [BW-1:0] work_mem [NW];
  logic [15:0]          knot_rd_r;
  logic [31:0]          ctrl_rd_r;
  logic signed [BW-1:0] work_rd_r;

  logic [15:0]          t_r, ka_r, kb_r, kc_r, kd_r;
  logic signed [BW-1:0] wa_r, wb_r, c1_r, c2_r;
  logic signed [51:0]   p1_r, p2_r;
  logic signed [52:0]   sum_r;
  logic signed [41:0]   px_r, py_r;
  logic signed [AW-1:0] accx_r, accy_r;
  logic signed [15:0]   outx_r, outy_r;
  logic                 neg_r;
  bcpe_pkg::coef_t      csel_r;

  // coefficient operands
  logic signed [16:0] num, den, num_abs, den_abs;
  logic               hit, wzero;
  logic               div_start, div_busy, div_done;
  logic [31:0]        div_q;
  logic [24:0]        qmag;
  logic signed [BW-1:0] qval, cimm;
  logic signed [BW-1:0] init_val, basis_val;

  always_comb begin
    if (cmd.coef_sel == bcpe_pkg::COEF_1) begin
      num   = $signed({1'b0, t_r}) - $signed({1'b0, ka_r});
      den   = $signed({1'b0, kc_r}) - $signed({1'b0, ka_r});
      hit   = (t_r == ka_r);
      wzero = (wa_r == '0);
    end else begin
      num   = $signed({1'b0, kd_r}) - $signed({1'b0, t_r});
      den   = $signed({1'b0, kd_r}) - $signed({1'b0, kb_r});
      hit   = (t_r == kd_r);
      wzero = (wb_r == '0);
    end
    num_abs   = num[16] ? -num : num;
    den_abs   = den[16] ? -den : den;
    cimm      = (!wzero && hit) ? BW'(bcpe_pkg::ONE_Q16) : '0;
    div_start = cmd.coef_start && !wzero && (den != '0);
    qmag      = (div_q > 32'd16777216) ? 25'd16777216 : div_q[24:0];
    qval      = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    init_val  = (ka_r <= t_r && t_r < kb_r) ? BW'(bcpe_pkg::ONE_Q16) : '0;
    basis_val = basis_rnd(sum_r);
  end

  bcpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({num_abs[15:0], 16'd0}),
    .den   (den_abs[15:0]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign stat.coef_busy = div_busy;

  always_ff @(posedge clk) begin
    if (cmd.knot_we && in_slot < 6'(NK))
      knot_mem[in_slot[KAW-1:0]] <= in_knot_value;
    if (cmd.ctrl_we && in_slot < 6'(NUM_CTRL))
      ctrl_mem[in_slot[CAW-1:0]] <= {in_point_x, in_point_y};
    if (cmd.init_we)
      work_mem[cmd.work_addr[WAW-1:0]] <= init_val;
    else if (cmd.basis_we)
      work_mem[cmd.work_addr[WAW-1:0]] <= basis_val;
    knot_rd_r <= knot_mem[cmd.knot_addr[KAW-1:0]];
    work_rd_r <= work_mem[cmd.work_addr[WAW-1:0]];
    ctrl_rd_r <= ctrl_mem[cmd.work_addr[CAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.t_load) begin
      t_r    <= in_param_t;
      accx_r <= '0;
      accy_r <= '0;
    end else if (cmd.acc_add) begin
      accx_r <= accx_r + AW'(px_r);
      accy_r <= accy_r + AW'(py_r);
    end
    if (cmd.cap_en) begin
      unique case (cmd.cap_sel)
        bcpe_pkg::CAP_A: begin
          ka_r <= knot_rd_r;
          wa_r <= work_rd_r;
        end
        bcpe_pkg::CAP_B: begin
          kb_r <= knot_rd_r;
          wb_r <= work_rd_r;
        end
        bcpe_pkg::CAP_C: kc_r <= knot_rd_r;
        bcpe_pkg::CAP_D: kd_r <= knot_rd_r;
        default: ;
      endcase
    end
    if (cmd.coef_start) begin
      neg_r  <= num[16] ^ den[16];
      csel_r <= cmd.coef_sel;
      if (!div_start) begin
        if (cmd.coef_sel == bcpe_pkg::COEF_1) c1_r <= cimm;
        else c2_r <= cimm;
      end
    end else if (div_done) begin
      if (csel_r == bcpe_pkg::COEF_1) c1_r <= qval;
      else c2_r <= qval;
    end
    if (cmd.mul_en) begin
      p1_r <= c1_r * wa_r;
      p2_r <= c2_r * wb_r;
    end
    if (cmd.sum_en)
      sum_r <= 53'(p1_r) + 53'(p2_r);
    if (cmd.acc_mul) begin
      px_r <= $signed(ctrl_rd_r[31:16]) * work_rd_r;
      py_r <= $signed(ctrl_rd_r[15:0]) * work_rd_r;
    end
    if (cmd.out_load) begin
      outx_r <= curve_rnd(accx_r);
      outy_r <= curve_rnd(accy_r);
    end
  end

  assign out_curve_x = outx_r;
  assign out_curve_y = outy_r;

endmodule
`default_nettype wire

@@ rtl/core/bcpe_ctrl.sv @@
// Controller: sequences table writes, Cox-de Boor passes and the weighted sum.
`default_nettype none
module bcpe_ctrl #(
  parameter int NUM_CTRL = bcpe_pkg::NUM_CTRL_DEF,
  parameter int ORDER    = bcpe_pkg::ORDER_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     in_operation,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bcpe_pkg::cmd_t      cmd,
  input  wire bcpe_pkg::stat_t stat
);

  localparam int NK = NUM_CTRL + ORDER;
  localparam int IW = bcpe_pkg::IDX_W;
  localparam int KW = bcpe_pkg::K_W;

  bcpe_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [2:0]       f_r, f_nxt;
  logic             ov_r, ov_nxt;
  logic [IW-1:0]    last_i, ik;
  logic             accept;
  bcpe_pkg::op_t    op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcpe_pkg::S_IDLE;
      i_r     <= '0;
      k_r     <= '0;
      f_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      f_r     <= f_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    f_nxt     = f_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    op        = bcpe_pkg::op_t'(in_operation);
    in_stall  = (state_r != bcpe_pkg::S_IDLE);
    accept    = in_valid && !in_stall;
    last_i    = IW'(NK - 1) - IW'(k_r);
    ik        = i_r + IW'(k_r);

    unique case (state_r)
      bcpe_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op)
            bcpe_pkg::OP_WR_KNOT: cmd.knot_we = 1'b1;
            bcpe_pkg::OP_WR_CTRL: cmd.ctrl_we = 1'b1;
            bcpe_pkg::OP_EVAL: begin
              cmd.t_load = 1'b1;
              i_nxt      = '0;
              k_nxt      = KW'(1);
              f_nxt      = '0;
              state_nxt  = bcpe_pkg::S_FETCH;
            end
            default: ;
          endcase
        end
      end
      bcpe_pkg::S_FETCH: begin
        unique case (f_r)
          3'd0: cmd.knot_addr = i_r;
          3'd1: cmd.knot_addr = i_r + IW'(1);
          3'd2: cmd.knot_addr = ik - IW'(1);
          default: cmd.knot_addr = ik;
        endcase
        cmd.work_addr = (f_r == 3'd0 || k_r == KW'(1)) ? i_r : i_r + IW'(1);
        cmd.cap_en    = (f_r != 3'd0);
        cmd.cap_sel   = bcpe_pkg::cap_t'(2'(f_r - 3'd1));
        f_nxt         = f_r + 3'd1;
        if (f_r == 3'd4) begin
          f_nxt     = '0;
          state_nxt = (k_r == KW'(1)) ? bcpe_pkg::S_INIT_WR : bcpe_pkg::S_C1;
        end
      end
      bcpe_pkg::S_C1: begin
        cmd.coef_start = 1'b1;
        cmd.coef_sel   = bcpe_pkg::COEF_1;
        state_nxt      = bcpe_pkg::S_C1W;
      end
      bcpe_pkg::S_C1W: begin
        if (!stat.coef_busy) state_nxt = bcpe_pkg::S_C2;
      end
      bcpe_pkg::S_C2: begin
        cmd.coef_start = 1'b1;
        cmd.coef_sel   = bcpe_pkg::COEF_2;
        state_nxt      = bcpe_pkg::S_C2W;
      end
      bcpe_pkg::S_C2W: begin
        if (!stat.coef_busy) state_nxt = bcpe_pkg::S_MUL;
      end
      bcpe_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = bcpe_pkg::S_SUM;
      end
      bcpe_pkg::S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = bcpe_pkg::S_BWR;
      end
      bcpe_pkg::S_INIT_WR, bcpe_pkg::S_BWR: begin
        cmd.work_addr = i_r;
        cmd.init_we   = (state_r == bcpe_pkg::S_INIT_WR);
        cmd.basis_we  = (state_r == bcpe_pkg::S_BWR);
        if (i_r == last_i) begin
          i_nxt = '0;
          if (k_r == KW'(ORDER)) begin
            state_nxt = bcpe_pkg::S_A_RD;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = bcpe_pkg::S_FETCH;
          end
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = bcpe_pkg::S_FETCH;
        end
      end
      bcpe_pkg::S_A_RD: begin
        cmd.work_addr = i_r;
        state_nxt     = bcpe_pkg::S_A_MUL;
      end
      bcpe_pkg::S_A_MUL: begin
        cmd.acc_mul = 1'b1;
        state_nxt   = bcpe_pkg::S_A_ACC;
      end
      bcpe_pkg::S_A_ACC: begin
        cmd.acc_add = 1'b1;
        if (i_r == IW'(NUM_CTRL - 1)) begin
          state_nxt = bcpe_pkg::S_OUT;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = bcpe_pkg::S_A_RD;
        end
      end
      bcpe_pkg::S_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = bcpe_pkg::S_IDLE;
        end
      end
      default: state_nxt = bcpe_pkg::S_IDLE;
    endcase
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

@@ rtl/core/bspline_curve_point_evaluator.sv @@
// Top level: cubic B-spline curve point evaluator (Cox-de Boor), controller plus datapath.
// Write requests (knot or control point) are stored as they are accepted; in_stall stays low for them.
// Evaluate: order-1 basis init, then passes k=2..ORDER of two coefficients per entry (each on
// the 32-step divider unless trivial), then the weighted sum over NUM_CTRL control points.
// One request in flight at a time; the result register holds while the next request runs.
// rst_n is synchronous, active low: clears controller state and out_valid; tables undefined.
`default_nettype none
module bspline_curve_point_evaluator #(
  parameter int NUM_CTRL = bcpe_pkg::NUM_CTRL_DEF,
  parameter int ORDER    = bcpe_pkg::ORDER_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [5:0]         in_slot,
  input  wire logic [15:0]        in_knot_value,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic [15:0]        in_param_t,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_curve_x,
  output logic signed [15:0]      out_curve_y
);

  bcpe_pkg::cmd_t  cmd;
  bcpe_pkg::stat_t stat;

  // Controller walks i/k over the basis table; datapath holds every store and arithmetic unit.
  bcpe_ctrl #(
    .NUM_CTRL (NUM_CTRL),
    .ORDER    (ORDER)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  bcpe_datapath #(
    .NUM_CTRL (NUM_CTRL),
    .ORDER    (ORDER)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_slot       (in_slot),
    .in_knot_value (in_knot_value),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_param_t    (in_param_t),
    .out_curve_x   (out_curve_x),
    .out_curve_y   (out_curve_y)
  );

endmodule
`default_nettype wire
